// ----- hdl/counting_semaphore_table_defines.svh -----
// ----------------------------------------------------------------------------
// counting semaphore table assertion macros
// shared assertion forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef COUNTING_SEMAPHORE_TABLE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_DEFINES_SVH

// same-cycle implication
`define CST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/cst_pkg.sv -----
// ----------------------------------------------------------------------------
// cst_pkg
// types, sizes and codes shared by the semaphore table modules
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

	localparam int SEM_COUNT  = 16;
	localparam int WAIT_DEPTH = 8;

	localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
	localparam int QW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int FW = $clog2(WAIT_DEPTH + 1);
	localparam int WAIT_ENTRIES = SEM_COUNT * WAIT_DEPTH;
	localparam int AW = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;

	localparam logic [1:0] OP_CREATE  = 2'd0;
	localparam logic [1:0] OP_DESTROY = 2'd1;
	localparam logic [1:0] OP_WAIT    = 2'd2;
	localparam logic [1:0] OP_SIGNAL  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_QUEUED  = 3'd2;
	localparam logic [2:0] ST_WOKEN   = 3'd3;
	localparam logic [2:0] ST_CANCEL  = 3'd4;
	localparam logic [2:0] ST_FULL    = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_CANCEL,
		S_FIN,
		S_WAKE
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic cancel;
		logic fin;
		logic wake;
	} cst_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic can_emit;
		logic need_cancel;
		logic need_wake;
		logic cancel_last;
	} cst_stat_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hff) ? v : v + 8'd1;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/cst_req_if.sv -----
// ----------------------------------------------------------------------------
// cst_req_if
// request channel: valid/ready handshake with one request word
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [3:0]  sem_index;
	logic [15:0] owner_id;
	logic [15:0] thread_id;
	logic [7:0]  capacity;

	modport source (output valid, op, sem_index, owner_id, thread_id, capacity,
		input ready);
	modport sink (input valid, op, sem_index, owner_id, thread_id, capacity,
		output ready);
endinterface

`default_nettype wire

// ----- hdl/cst_res_if.sv -----
// ----------------------------------------------------------------------------
// cst_res_if
// result channel: valid/ready handshake with one result word
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  sem_index_res;
	logic [15:0] thread_id_res;
	logic [15:0] owner_id_res;
	logic        last;

	modport source (output valid, status, sem_index_res, thread_id_res, owner_id_res,
		last, input ready);
	modport sink (input valid, status, sem_index_res, thread_id_res, owner_id_res,
		last, output ready);
endinterface

`default_nettype wire

// ----- hdl/cst_ram.sv -----
// ----------------------------------------------------------------------------
// cst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata_q
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end
endmodule

`default_nettype wire

// ----- hdl/cst_ctl.sv -----
// ----------------------------------------------------------------------------
// cst_ctl
// request sequencer: accept, execute, cancel sweep, wake step
// ----------------------------------------------------------------------------
`default_nettype none

module cst_ctl
	import cst_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire cst_stat_t stat,
	output cst_cmd_t       cmd
);
	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.can_emit) begin
					cmd.exec = 1'b1;
					if (stat.need_cancel) state_d = S_CANCEL;
					else if (stat.need_wake) state_d = S_WAKE;
					else state_d = S_IDLE;
				end
			end
			S_CANCEL: begin
				if (stat.can_emit) begin
					cmd.cancel = 1'b1;
					if (stat.cancel_last) state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.can_emit) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_WAKE: begin
				if (stat.can_emit) begin
					cmd.wake = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

`default_nettype wire

// ----- hdl/cst_dp.sv -----
// ----------------------------------------------------------------------------
// cst_dp
// slot table, waiter ram, request latch and result register
// ----------------------------------------------------------------------------
`default_nettype none

module cst_dp
	import cst_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	cst_req_if.sink       req,
	cst_res_if.source     res,
	input  wire cst_cmd_t cmd,
	output cst_stat_t     stat
);
	// latched request
	logic [1:0]  op_q;
	logic [3:0]  idx_q;
	logic [15:0] pid_q, tid_q;
	logic [7:0]  cap_q;

	// slot table
	logic [SEM_COUNT-1:0] valid_q;
	logic [7:0]  capa_q  [SEM_COUNT];
	logic [7:0]  count_q [SEM_COUNT];
	logic [15:0] owner_q [SEM_COUNT];
	logic [QW-1:0] head_q [SEM_COUNT];
	logic [FW-1:0] fill_q [SEM_COUNT];

	// cancel sweep cursor
	logic [QW-1:0] pos_q;
	logic [FW-1:0] rem_q;

	// result register
	logic        ovalid_q;
	logic [2:0]  ost_q;
	logic [3:0]  oidx_q;
	logic [15:0] otid_q, opid_q;
	logic        olast_q;

	logic [SW-1:0] sidx;
	logic          in_range, ok, owner_ok, fill_zero, fill_full, grant, free_any;
	logic [SW-1:0] free_idx;
	logic [7:0]    cnt, cnt_dec;
	logic [QW-1:0] head, head_nx, pos_nx, tail;
	logic [FW:0]   tail_sum;
	logic [FW-1:0] fill;
	logic          ram_we, ram_re;
	logic [AW-1:0] base, ram_waddr, ram_raddr;
	logic [31:0]   ram_rdata;
	logic          emit;
	logic [2:0]    e_st;
	logic [15:0]   e_tid, e_pid;
	logic [3:0]    e_idx;
	logic          e_last;

	function automatic logic [QW-1:0] pos_inc(input logic [QW-1:0] p);
		return ({1'b0, p} == (QW+1)'(WAIT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign sidx      = SW'(idx_q);
	assign in_range  = ({5'd0, idx_q} < 9'(SEM_COUNT));
	assign ok        = in_range && valid_q[sidx];
	assign owner_ok  = (owner_q[sidx] == pid_q);
	assign cnt       = count_q[sidx];
	assign cnt_dec   = (cnt != 8'd0) ? cnt - 8'd1 : cnt;
	assign head      = head_q[sidx];
	assign head_nx   = pos_inc(head);
	assign fill      = fill_q[sidx];
	assign fill_zero = (fill == '0);
	assign fill_full = ({1'b0, fill} >= (FW+1)'(WAIT_DEPTH));
	assign grant     = (cnt < capa_q[sidx]);
	assign tail_sum  = (FW+1)'(head) + (FW+1)'(fill);
	assign tail      = (tail_sum >= (FW+1)'(WAIT_DEPTH)) ?
		QW'(tail_sum - (FW+1)'(WAIT_DEPTH)) : QW'(tail_sum);
	assign pos_nx    = pos_inc(pos_q);
	assign base      = AW'(sidx) * AW'(WAIT_DEPTH);

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SEM_COUNT - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	assign stat.can_emit    = !ovalid_q || res.ready;
	assign stat.need_cancel = (op_q == OP_DESTROY) && ok && owner_ok && !fill_zero;
	assign stat.need_wake   = (op_q == OP_SIGNAL) && ok && !fill_zero;
	assign stat.cancel_last = (rem_q == FW'(1));

	// ram port control and result selection
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = base + AW'(tail);
		ram_raddr = base + AW'(head);
		emit      = 1'b0;
		e_st      = ST_OK;
		e_idx     = idx_q;
		e_tid     = tid_q;
		e_pid     = pid_q;
		e_last    = 1'b1;
		if (cmd.exec) begin
			emit = 1'b1;
			if (op_q == OP_CREATE) begin
				e_st  = free_any ? ST_OK : ST_FULL;
				e_idx = free_any ? 4'(free_idx) : 4'd0;
			end else if (!ok || (op_q == OP_DESTROY && !owner_ok)) begin
				e_st = ST_INVALID;
			end else begin
				case (op_q)
					OP_DESTROY: begin
						ram_re = !fill_zero;
						emit   = fill_zero;
					end
					OP_WAIT: begin
						if (grant) e_st = ST_OK;
						else if (fill_full) e_st = ST_FULL;
						else begin
							e_st   = ST_QUEUED;
							ram_we = 1'b1;
						end
					end
					OP_SIGNAL: begin
						e_last = fill_zero;
						ram_re = !fill_zero;
					end
					default: e_st = ST_OK;
				endcase
			end
		end
		if (cmd.cancel) begin
			emit      = 1'b1;
			e_st      = ST_CANCEL;
			e_tid     = ram_rdata[31:16];
			e_pid     = ram_rdata[15:0];
			e_last    = 1'b0;
			ram_re    = !stat.cancel_last;
			ram_raddr = base + AW'(pos_q);
		end
		if (cmd.fin) begin
			emit = 1'b1;
		end
		if (cmd.wake) begin
			emit  = 1'b1;
			e_st  = ST_WOKEN;
			e_tid = ram_rdata[31:16];
			e_pid = ram_rdata[15:0];
		end
	end

	cst_ram #(.WIDTH(32), .DEPTH(WAIT_ENTRIES)) u_wait_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   ({tid_q, pid_q}),
		.re      (ram_re),
		.raddr   (ram_raddr),
		.rdata_q (ram_rdata)
	);

	// request latch and cursor
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= req.op;
			idx_q <= req.sem_index;
			pid_q <= req.owner_id;
			tid_q <= req.thread_id;
			cap_q <= req.capacity;
		end
		if (cmd.exec) begin
			pos_q <= head_nx;
			rem_q <= fill;
		end else if (cmd.cancel) begin
			pos_q <= pos_nx;
			rem_q <= rem_q - FW'(1);
		end
	end

	// slot table updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < SEM_COUNT; i++) begin
				capa_q[i]  <= '0;
				count_q[i] <= '0;
				owner_q[i] <= '0;
				head_q[i]  <= '0;
				fill_q[i]  <= '0;
			end
		end else begin
			if (cmd.exec && op_q == OP_CREATE && free_any) begin
				valid_q[free_idx] <= 1'b1;
				capa_q[free_idx]  <= cap_q;
				count_q[free_idx] <= '0;
				owner_q[free_idx] <= pid_q;
				head_q[free_idx]  <= '0;
				fill_q[free_idx]  <= '0;
			end
			if (cmd.exec && ok && op_q == OP_DESTROY && owner_ok && fill_zero) begin
				valid_q[sidx] <= 1'b0;
				head_q[sidx]  <= '0;
			end
			if (cmd.exec && ok && op_q == OP_WAIT) begin
				if (grant) count_q[sidx] <= sat_inc(cnt);
				else if (!fill_full) fill_q[sidx] <= fill + FW'(1);
			end
			if (cmd.exec && ok && op_q == OP_SIGNAL) begin
				count_q[sidx] <= cnt_dec;
			end
			if (cmd.fin) begin
				valid_q[sidx] <= 1'b0;
				head_q[sidx]  <= '0;
				fill_q[sidx]  <= '0;
			end
			if (cmd.wake) begin
				head_q[sidx]  <= head_nx;
				fill_q[sidx]  <= fill - FW'(1);
				count_q[sidx] <= sat_inc(cnt);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit) begin
			ovalid_q <= 1'b1;
		end else if (res.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ost_q   <= e_st;
			oidx_q  <= e_idx;
			otid_q  <= e_tid;
			opid_q  <= e_pid;
			olast_q <= e_last;
		end
	end

	assign res.valid         = ovalid_q;
	assign res.status        = ost_q;
	assign res.sem_index_res = oidx_q;
	assign res.thread_id_res = otid_q;
	assign res.owner_id_res  = opid_q;
	assign res.last          = olast_q;
endmodule

`default_nettype wire

// ----- hdl/counting_semaphore_table.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_table
// table of counting semaphores with per-slot fifo wait queues
// ----------------------------------------------------------------------------
// usage:
//   req channel takes one request word: op (create, destroy, wait, signal),
//   slot index, owner id, thread id and capacity for create
//   res channel gives one or more result words per request; last marks the
//   final word of a request
// sequencing:
//   ready is high only while the sequencer is idle; one request at a time
//   create, wait and invalid requests: accept, then execute with one word
//   signal with a waiter: accept, execute, wake (second word needs ram read)
//   destroy: accept, execute, then with waiters one cancel each and a finish
//   every word leaves through a single output register, at most one per cycle
//   when not stalled, so the rate is set by the sequencer and waiter ram read
// reset:
//   arst_n clears every slot (no semaphores, empty queues); the waiter ram
//   is not cleared, entries are only read after being queued
// stall:
//   when res.ready is low the sequencer holds in place until the output
//   register frees up; no word is dropped or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_table
	import cst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	cst_req_if.sink   req,
	cst_res_if.source res
);
	cst_cmd_t  cmd;
	cst_stat_t stat;
	logic      ready;

	// sequencer
	cst_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	assign req.ready = ready;

	// table, waiter ram and output register
	cst_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cmd    (cmd),
		.stat   (stat)
	);
endmodule

`default_nettype wire

// ----- hdl/cst_checker.sv -----
// ----------------------------------------------------------------------------
// cst_checker
// port-level checks for the semaphore table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "counting_semaphore_table_defines.svh"

module cst_checker
	import cst_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [2:0]  res_status,
	input wire logic [15:0] res_tid,
	input wire logic        res_last
);
	`CST_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_tid) && $stable(res_last), "result word changed while stalled")
	`CST_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
	`CST_ASSERT_NOW(a_woken_last, res_valid && res_status == ST_WOKEN, res_last, "woken word not last")
	`CST_ASSERT_NOW(a_cancel_not_last, res_valid && res_status == ST_CANCEL, !res_last, "cancel word marked last")
	`CST_ASSERT_NOW(a_status_code, res_valid, res_status <= ST_FULL, "unknown status code")
endmodule

bind counting_semaphore_table cst_checker u_cst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.res_status (res.status),
	.res_tid    (res.thread_id_res),
	.res_last   (res.last)
);

`default_nettype wire
